// File: design/ped_pkg.sv
`default_nettype none

package ped_pkg;

  // Widest bitmap the block supports: four bytes of eight events each.
  localparam int unsigned MAX_EVENT_BYTES = 4;
  localparam int unsigned MAX_IDS         = MAX_EVENT_BYTES * 8;
  localparam int unsigned ID_W            = 5;
  localparam int unsigned DEF_EVENT_BYTES = 4;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_PROCESS = 2'd2
  } op_t;

  // One dispatch job: the enabled pending bits of both banks, snapshotted.
  typedef struct packed {
    logic [MAX_IDS-1:0] norm;
    logic [MAX_IDS-1:0] imm;
  } job_t;

  // Isolate the lowest set bit of a vector.
  function automatic logic [MAX_IDS-1:0] lowest_bit(input logic [MAX_IDS-1:0] vec);
    return vec & (~vec + MAX_IDS'(1));
  endfunction

  // Index of the lowest set bit; zero for an empty vector.
  function automatic logic [ID_W-1:0] lowest_index(input logic [MAX_IDS-1:0] vec);
    logic [MAX_IDS-1:0] low;
    logic [ID_W-1:0]    idx;
    low = lowest_bit(vec);
    idx = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      if (low[i]) begin
        idx = idx | ID_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: design/ped_front.sv
`default_nettype none

module ped_front #(
  parameter int unsigned EVENT_BYTES = ped_pkg::DEF_EVENT_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic                   in_bank,
  input  wire logic [4:0]             in_event_id,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [31:0]            cfg_handler_enable_mask,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output ped_pkg::job_t               push_job
);

  // A byte count above the widest supported bitmap acts as the widest one.
  localparam int unsigned BytesUsed = (EVENT_BYTES > ped_pkg::MAX_EVENT_BYTES) ?
                                      ped_pkg::MAX_EVENT_BYTES : EVENT_BYTES;
  localparam int unsigned IdCount   = BytesUsed * 8;

  logic [IdCount-1:0] norm_r, norm_nxt;
  logic [IdCount-1:0] imm_r, imm_nxt;
  logic               norm_act_r, norm_act_nxt;
  logic               imm_act_r, imm_act_nxt;
  logic [31:0]        mask_r;
  logic               in_fire;
  logic               in_range;
  logic [IdCount-1:0] sel;
  logic [31:0]        sel_full;

  // A beat is taken whenever the job queue has room.
  assign in_ready  = push_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Decode the event bit and check that its byte lies inside the bitmap.
  assign in_range = ({1'b0, in_event_id[4:3]} < 3'(BytesUsed));
  assign sel_full = 32'd1 << in_event_id;
  assign sel      = sel_full[IdCount-1:0];

  // Snapshot of the enabled pending bits, handed to the back end on process.
  assign push_job.norm = norm_act_r ? ped_pkg::MAX_IDS'(norm_r & mask_r[IdCount-1:0]) : '0;
  assign push_job.imm  = imm_act_r ? ped_pkg::MAX_IDS'(imm_r & mask_r[IdCount-1:0]) : '0;

  // Apply set and clear beats; a process beat clears both banks and queues a job.
  always_comb begin
    norm_nxt     = norm_r;
    imm_nxt      = imm_r;
    norm_act_nxt = norm_act_r;
    imm_act_nxt  = imm_act_r;
    push_valid   = 1'b0;
    if (in_fire) begin
      unique case (ped_pkg::op_t'(in_op))
        ped_pkg::OP_SET, ped_pkg::OP_CLEAR: begin
          if (in_range) begin
            if (in_bank) begin
              imm_nxt     = (in_op == ped_pkg::OP_SET) ? (imm_r | sel) : (imm_r & ~sel);
              imm_act_nxt = 1'b1;
            end else begin
              norm_nxt     = (in_op == ped_pkg::OP_SET) ? (norm_r | sel) : (norm_r & ~sel);
              norm_act_nxt = 1'b1;
            end
          end
        end
        ped_pkg::OP_PROCESS: begin
          push_valid   = 1'b1;
          norm_nxt     = '0;
          imm_nxt      = '0;
          norm_act_nxt = 1'b0;
          imm_act_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Bank state and the handler enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r     <= '0;
      imm_r      <= '0;
      norm_act_r <= 1'b0;
      imm_act_r  <= 1'b0;
      mask_r     <= '0;
    end else begin
      norm_r     <= norm_nxt;
      imm_r      <= imm_nxt;
      norm_act_r <= norm_act_nxt;
      imm_act_r  <= imm_act_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_handler_enable_mask;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ped_queue.sv
`default_nettype none

module ped_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire ped_pkg::job_t  push_job,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output ped_pkg::job_t       pop_job
);

  localparam int unsigned PtrW = $clog2(ped_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(ped_pkg::QUEUE_DEPTH + 1);

  ped_pkg::job_t entries_r [ped_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CntW'(ped_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(ped_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(ped_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    count_nxt = count_r + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(ped_pkg::QUEUE_DEPTH))
    else $error("job queue occupancy out of range");

endmodule

`default_nettype wire

// File: design/ped_back.sv
`default_nettype none

module ped_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire ped_pkg::job_t  pop_job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [4:0]          out_dispatched_id,
  output logic                out_from_immediate,
  output logic                out_last
);

  logic [ped_pkg::MAX_IDS-1:0] work_norm_r, work_norm_nxt;
  logic [ped_pkg::MAX_IDS-1:0] work_imm_r, work_imm_nxt;
  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [4:0]                  out_id_r;
  logic                        out_imm_r;
  logic                        out_last_r;
  logic                        load_en;
  logic                        norm_any;
  logic                        pick_imm;
  logic [4:0]                  pick_id;
  logic [ped_pkg::MAX_IDS-1:0] rem_norm;
  logic [ped_pkg::MAX_IDS-1:0] rem_imm;
  logic                        pick_last;

  assign out_valid          = out_valid_r;
  assign out_dispatched_id  = out_id_r;
  assign out_from_immediate = out_imm_r;
  assign out_last           = out_last_r;

  // A new job is taken only once the scan of the previous one has picked its final id.
  assign pop_ready = !busy_r;
  assign load_en   = busy_r && (!out_valid_r || out_ready);

  // Pick the lowest pending id, normal bank before immediate bank.
  assign norm_any  = (work_norm_r != '0);
  assign pick_imm  = !norm_any;
  assign pick_id   = norm_any ? ped_pkg::lowest_index(work_norm_r)
                              : ped_pkg::lowest_index(work_imm_r);
  assign rem_norm  = norm_any ? (work_norm_r & ~ped_pkg::lowest_bit(work_norm_r)) : work_norm_r;
  assign rem_imm   = norm_any ? work_imm_r : (work_imm_r & ~ped_pkg::lowest_bit(work_imm_r));
  assign pick_last = (rem_norm == '0) && (rem_imm == '0);

  // Job load and per-beat bit retirement.
  always_comb begin
    work_norm_nxt = work_norm_r;
    work_imm_nxt  = work_imm_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (!busy_r && pop_valid) begin
      work_norm_nxt = pop_job.norm;
      work_imm_nxt  = pop_job.imm;
      busy_nxt      = (pop_job.norm != '0) || (pop_job.imm != '0);
    end else if (load_en) begin
      work_norm_nxt = rem_norm;
      work_imm_nxt  = rem_imm;
      busy_nxt      = !pick_last;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    work_norm_r <= work_norm_nxt;
    work_imm_r  <= work_imm_nxt;
    if (load_en) begin
      out_id_r   <= pick_id;
      out_imm_r  <= pick_imm;
      out_last_r <= pick_last;
    end
  end

  // A busy scan always has a pending bit left to emit.
  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((work_norm_r != '0) || (work_imm_r != '0)))
    else $error("scan busy with empty work vectors");

  // Emitting the final id ends the scan.
  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en && pick_last) |=> !busy_r)
    else $error("scan still busy after final id");

  // Once the immediate bank is reached no normal id remains.
  a_imm_after_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en && pick_imm && !pick_last) |=> (work_norm_r == '0))
    else $error("normal id left after immediate dispatch began");

endmodule

`default_nettype wire

// File: design/pending_event_dispatcher.sv
`default_nettype none

// Pending event dispatcher. Set and clear beats (op 0 and 1) mark or unmark
// one event bit in the normal (bank 0) or immediate (bank 1) bitmap and are
// taken one per cycle. A process beat (op 2) snapshots both bitmaps, masked
// by the handler enable register, clears them, and queues the snapshot; the
// dispatch unit then emits every enabled pending id, normal bank first, each
// bank in ascending order, one result beat per cycle while out_ready holds,
// with last set on the final one. A process beat with nothing to dispatch
// yields no result. The front end takes one beat per cycle as long as the
// two-entry job queue has room; the output side sets the rate of a stream
// of process beats. The user must write the enable register through the
// cfg port only while the block is idle; the block does not enforce this,
// and the register has no other effect on timing.
module pending_event_dispatcher #(
  parameter int unsigned EVENT_BYTES = ped_pkg::DEF_EVENT_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic       in_bank,
  input  wire logic [4:0] in_event_id,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_dispatched_id,
  output logic            out_from_immediate,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [31:0] cfg_handler_enable_mask
);

  logic          push_valid;
  logic          push_ready;
  ped_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  ped_pkg::job_t pop_job;

  // Front end: bank bitmaps, enable register and classification.
  ped_front #(
    .EVENT_BYTES(EVENT_BYTES)
  ) u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_op                   (in_op),
    .in_bank                 (in_bank),
    .in_event_id             (in_event_id),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_handler_enable_mask (cfg_handler_enable_mask),
    .push_valid              (push_valid),
    .push_ready              (push_ready),
    .push_job                (push_job)
  );

  // Queue of dispatch jobs.
  ped_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back end: scans each job and emits ids.
  ped_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_job            (pop_job),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dispatched_id  (out_dispatched_id),
    .out_from_immediate (out_from_immediate),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// File: bench/pending_event_dispatcher_test.sv
`timescale 1ns / 1ps

module pending_event_dispatcher_test;

  localparam int unsigned EVENT_BYTES = 4;
  localparam int unsigned ID_COUNT    = EVENT_BYTES * 8;

  // Opcode the block does not define; it must be ignored.
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic       BANK_NORMAL    = 1'b0;
  localparam logic       BANK_IMMEDIATE = 1'b1;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int MAX_PRINTED   = 40;

  // One dispatched id as it should leave the block.
  typedef struct packed {
    logic [ped_pkg::ID_W-1:0] id;
    logic                     from_imm;
    logic                     last;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = ped_pkg::OP_SET;
  logic        in_bank = BANK_NORMAL;
  logic [4:0]  in_event_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_dispatched_id;
  logic        out_from_immediate;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_handler_enable_mask = '0;

  // Shadow copy of the block's bitmaps, flags and handler mask.
  logic [31:0] enable_mask = '0;
  logic [31:0] norm_bits = '0;
  logic [31:0] imm_bits = '0;
  logic        norm_armed = 1'b0;
  logic        imm_armed = 1'b0;

  // Ids still to come out of the block, oldest first.
  dispatch_t dispatch_order[$];

  int  errors = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  mask_writes = 0;
  int  largest_burst = 0;
  int  idle_cycles = 0;
  bit  steady_mode = 1'b0;

  always #1 clk = ~clk;

  pending_event_dispatcher #(
    .EVENT_BYTES(EVENT_BYTES)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_op                   (in_op),
    .in_bank                 (in_bank),
    .in_event_id             (in_event_id),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_dispatched_id       (out_dispatched_id),
    .out_from_immediate      (out_from_immediate),
    .out_last                (out_last),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_handler_enable_mask (cfg_handler_enable_mask)
  );

  // Print one line per mismatch, up to a cap, and count them all.
  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  // Mostly short gaps, now and then a long one, none in steady mode.
  function automatic int pick_gap();
    int r;
    if (steady_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Queue the enabled ids of one bank snapshot in ascending order.
  function automatic int drain_snapshot(input logic [31:0] snap, input logic imm,
                                        input int count);
    dispatch_t d;
    int n;
    n = count;
    for (int i = 0; i < ID_COUNT; i++) begin
      if (snap[i] && enable_mask[i]) begin
        d.id       = ped_pkg::ID_W'(i);
        d.from_imm = imm;
        d.last     = 1'b0;
        dispatch_order.push_back(d);
        n++;
      end
    end
    return n;
  endfunction

  // Update the shadow state for one accepted input beat.
  function automatic void apply_event_beat(input logic [1:0] op, input logic bank,
                                           input logic [ped_pkg::ID_W-1:0] id);
    int count;
    logic [31:0] bit_sel;
    dispatch_t tail;
    count   = 0;
    bit_sel = 32'd1 << id;
    unique case (op)
      ped_pkg::OP_SET, ped_pkg::OP_CLEAR: begin
        // An id past the configured bitmap changes nothing at all.
        if ((id >> 3) < EVENT_BYTES) begin
          if (bank == BANK_IMMEDIATE) begin
            imm_bits  = (op == ped_pkg::OP_SET) ? (imm_bits | bit_sel)
                                                : (imm_bits & ~bit_sel);
            imm_armed = 1'b1;
          end else begin
            norm_bits  = (op == ped_pkg::OP_SET) ? (norm_bits | bit_sel)
                                                 : (norm_bits & ~bit_sel);
            norm_armed = 1'b1;
          end
        end
      end
      ped_pkg::OP_PROCESS: begin
        // Normal bank first, then one drain of the immediate bank.
        if (norm_armed) begin
          count      = drain_snapshot(norm_bits, BANK_NORMAL, count);
          norm_bits  = '0;
          norm_armed = 1'b0;
        end
        if (imm_armed) begin
          count     = drain_snapshot(imm_bits, BANK_IMMEDIATE, count);
          imm_bits  = '0;
          imm_armed = 1'b0;
        end
        if (count > 0) begin
          tail = dispatch_order.pop_back();
          tail.last = 1'b1;
          dispatch_order.push_back(tail);
        end
        if (count > largest_burst) begin
          largest_burst = count;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Send one input beat, wait for its handshake, then idle at random.
  task automatic push_event_beat(input logic [1:0] op, input logic bank,
                                 input logic [ped_pkg::ID_W-1:0] id);
    int gap;
    in_valid    <= 1'b1;
    in_op       <= op;
    in_bank     <= bank;
    in_event_id <= id;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    apply_event_beat(op, bank, id);
    if (op != OP_UNUSED) begin
      beats_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every queued dispatch come out, plus a short settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dispatch_order.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the handler mask once the block has gone quiet.
  task automatic load_enable_mask(input logic [31:0] value);
    wait_drained();
    cfg_valid               <= 1'b1;
    cfg_handler_enable_mask <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    enable_mask = value;
    mask_writes++;
    cfg_valid <= 1'b0;
  endtask

  // With no handlers enabled nothing is dispatched, and empty processing is quiet.
  task automatic test_disabled_handlers();
    load_enable_mask(32'h0000_0000);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd3);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd7);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_IMMEDIATE, 5'd31);
  endtask

  // Lowest and highest ids in both banks; the bank field of a process beat is ignored.
  task automatic test_extreme_ids();
    load_enable_mask(32'hFFFF_FFFF);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd31);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd0);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd0);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd31);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_IMMEDIATE, 5'd31);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
  endtask

  // Clears remove bits but still arm the bank, and the unused opcode does nothing.
  task automatic test_clear_and_unused();
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd5);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd5);
    push_event_beat(ped_pkg::OP_CLEAR, BANK_NORMAL, 5'd5);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd12);
    push_event_beat(OP_UNUSED, BANK_IMMEDIATE, 5'd20);
    push_event_beat(ped_pkg::OP_CLEAR, BANK_IMMEDIATE, 5'd30);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd9);
    push_event_beat(OP_UNUSED, BANK_NORMAL, 5'd9);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_IMMEDIATE, 5'd17);
  endtask

  // Pending ids without a handler are dropped from both banks.
  task automatic test_partial_mask();
    load_enable_mask(32'h0000_FFFF);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd2);
    push_event_beat(ped_pkg::OP_SET, BANK_NORMAL, 5'd20);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd15);
    push_event_beat(ped_pkg::OP_SET, BANK_IMMEDIATE, 5'd16);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
  endtask

  // Fill both bitmaps completely in random order for the longest burst.
  task automatic test_full_bitmaps();
    int ids [64];
    int j;
    int t;
    load_enable_mask(32'hFFFF_FFFF);
    for (int i = 0; i < 64; i++) begin
      ids[i] = i;
    end
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ids[i];
      ids[i] = ids[j];
      ids[j] = t;
    end
    steady_mode = 1'b1;
    for (int i = 0; i < 64; i++) begin
      push_event_beat(ped_pkg::OP_SET, (ids[i] >= 32) ? BANK_IMMEDIATE : BANK_NORMAL,
                      ped_pkg::ID_W'(ids[i] % 32));
    end
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
    push_event_beat(ped_pkg::OP_PROCESS, BANK_NORMAL, 5'd0);
    wait_drained();
    steady_mode = 1'b0;
  endtask

  // Rounds of random beats, mostly set and clear, each closed by a process beat, over several masks.
  task automatic test_random_traffic();
    logic [31:0] masks [5];
    int sent;
    int round_len;
    int r;
    logic [1:0] op;
    masks[0] = $urandom();
    masks[1] = 32'hAAAA_AAAA;
    masks[2] = 32'hFFFF_FFFF;
    masks[3] = 32'h8000_0001;
    masks[4] = $urandom();
    for (int p = 0; p < 5; p++) begin
      load_enable_mask(masks[p]);
      steady_mode = (p == 2);
      sent = 0;
      while (sent < 5) begin
        round_len = $urandom_range(0, 8);
        for (int k = 0; k < round_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 72) begin
            op = ped_pkg::OP_SET;
          end else if (r < 92) begin
            op = ped_pkg::OP_CLEAR;
          end else if (r < 96) begin
            op = OP_UNUSED;
          end else begin
            op = ped_pkg::OP_PROCESS;
          end
          push_event_beat(op, 1'($urandom_range(0, 1)),
                          ped_pkg::ID_W'($urandom_range(0, 31)));
          if (op != OP_UNUSED) begin
            sent++;
          end
        end
        push_event_beat(ped_pkg::OP_PROCESS, 1'($urandom_range(0, 1)),
                        ped_pkg::ID_W'($urandom_range(0, 31)));
        sent++;
      end
    end
    wait_drained();
    steady_mode = 1'b0;
  endtask

  // Main sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_handlers();
    test_extreme_ids();
    test_clear_and_unused();
    test_partial_mask();
    test_full_bitmaps();
    test_random_traffic();
    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d input beats, %0d dispatched ids and %0d mask writes",
             beats_sent, results_seen, mask_writes);
    $display("longest dispatch burst from one process beat: %0d ids", largest_burst);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: ready drops at random, with runs of steady acceptance.
  initial begin
    int hold;
    int gap;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare every accepted result beat with the oldest predicted dispatch.
  always @(posedge clk) begin
    dispatch_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (dispatch_order.size() == 0) begin
        report_mismatch($sformatf("id %0d dispatched with nothing pending",
                                  out_dispatched_id));
      end else begin
        want = dispatch_order.pop_front();
        if (out_dispatched_id !== want.id) begin
          report_mismatch($sformatf("dispatched_id got %0d expected %0d",
                                    out_dispatched_id, want.id));
        end
        if (out_from_immediate !== want.from_imm) begin
          report_mismatch($sformatf("from_immediate got %0b expected %0b for id %0d",
                                    out_from_immediate, want.from_imm, want.id));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last got %0b expected %0b for id %0d",
                                    out_last, want.last, want.id));
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
